### rtl/core/iorb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the in-order reassembly buffer
package iorb_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int HANDLE_BITS  = 32;

    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = $clog2(WINDOW_DEPTH);
    // handle bits above HANDLE_BITS are not stored
    localparam int STORE_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // 2^32 mod depth, the slot offset of a sequence number that wrapped
    localparam longint unsigned SEQ_SPAN = 64'h1_0000_0000;
    localparam int WRAP_REM = int'(SEQ_SPAN % WINDOW_DEPTH);

    typedef logic [SEQ_W-1:0]    t_seq;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [STORE_W-1:0]  t_store;
    typedef logic [HANDLE_W-1:0] t_handle;

    typedef enum logic {
        OP_APPEND   = 1'b0,
        OP_RETRIEVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_STORED    = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

### rtl/core/iorb_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module iorb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/iorb_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: accept, execute, respond
module iorb_ctrl
    import iorb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_valid,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_valid <= 1'b1;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.load = (r_state == S_IDLE) && i_start && !r_busy;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_busy     = r_busy;
    assign o_valid    = r_valid;

endmodule

### rtl/core/iorb_dp.sv
`timescale 1ns / 1ps
// datapath: window check, slot store, valid bits and expected number
module iorb_dp
    import iorb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic          i_operation,
    input  t_seq          i_seq_number,
    input  t_handle       i_payload_handle,
    output logic [1:0]    o_status,
    output t_handle       o_out_handle,
    output t_seq          o_out_seq_number,
    output logic          o_next_ready
);

    typedef logic signed [SLOT_W+1:0] t_sum;

    // captured transfer
    logic    r_op;
    t_seq    r_seq;
    t_store  r_handle;

    // block state
    t_seq                    r_exp;
    t_slot                   r_exp_slot;
    logic [WINDOW_DEPTH-1:0] r_slot_valid;

    // result
    t_status r_status;
    t_seq    r_out_seq;
    logic    r_deliv;

    t_seq    seq_dist;
    logic    in_win;
    logic    wrapped;
    t_sum    raw_slot;
    t_sum    fix_slot;
    t_slot   app_slot;
    t_slot   exp_slot_inc;
    logic    app_ok;
    logic    ret_ok;
    logic    ram_we;
    logic    ram_re;
    t_store  ram_rdata;

    always_comb begin
        seq_dist = r_seq - r_exp;
        in_win   = seq_dist < t_seq'(WINDOW_DEPTH);
        wrapped  = r_seq < r_exp;
        // slot of r_seq from the slot of r_exp without a divider
        raw_slot = t_sum'({2'b00, r_exp_slot}) + t_sum'({2'b00, seq_dist[SLOT_W-1:0]})
                 - (wrapped ? t_sum'(WRAP_REM) : t_sum'(0));
        if (raw_slot < t_sum'(0)) begin
            fix_slot = raw_slot + t_sum'(WINDOW_DEPTH);
        end else if (raw_slot >= t_sum'(WINDOW_DEPTH)) begin
            fix_slot = raw_slot - t_sum'(WINDOW_DEPTH);
        end else begin
            fix_slot = raw_slot;
        end
        app_slot = fix_slot[SLOT_W-1:0];

        // 0 mod depth after the sequence wraps
        if (r_exp == '1 || r_exp_slot == t_slot'(WINDOW_DEPTH - 1)) begin
            exp_slot_inc = '0;
        end else begin
            exp_slot_inc = r_exp_slot + t_slot'(1);
        end

        app_ok = in_win && !r_slot_valid[app_slot];
        ret_ok = r_slot_valid[r_exp_slot];
        ram_we = i_cmd.exec && (r_op == OP_APPEND) && app_ok;
        ram_re = i_cmd.exec && (r_op == OP_RETRIEVE) && ret_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_seq    <= i_seq_number;
            r_handle <= i_payload_handle[STORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp        <= t_seq'(1);
            r_exp_slot   <= t_slot'(1);
            r_slot_valid <= '0;
        end else if (i_cmd.exec) begin
            if (r_op == OP_APPEND) begin
                if (app_ok) begin
                    r_slot_valid[app_slot] <= 1'b1;
                end
            end else if (ret_ok) begin
                r_slot_valid[r_exp_slot] <= 1'b0;
                r_exp                    <= r_exp + t_seq'(1);
                r_exp_slot               <= exp_slot_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == OP_APPEND) begin
                r_status  <= app_ok ? ST_STORED : ST_REJECTED;
                r_out_seq <= '0;
                r_deliv   <= 1'b0;
            end else if (ret_ok) begin
                r_status  <= ST_DELIVERED;
                r_out_seq <= r_exp;
                r_deliv   <= 1'b1;
            end else begin
                r_status  <= ST_NOT_READY;
                r_out_seq <= '0;
                r_deliv   <= 1'b0;
            end
        end
    end

    iorb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (app_slot),
        .i_wdata (r_handle),
        .i_re    (ram_re),
        .i_raddr (r_exp_slot),
        .o_rdata (ram_rdata)
    );

    assign o_status         = r_status;
    assign o_out_seq_number = r_out_seq;
    assign o_out_handle     = r_deliv ? t_handle'(ram_rdata) : '0;
    // state is already updated, so this is the slot of the number now expected
    assign o_next_ready     = r_slot_valid[r_exp_slot];

endmodule

### rtl/core/in_order_reassembly_buffer_top.sv
`timescale 1ns / 1ps
// in-order reassembly buffer: top level
// an item is accepted in S_IDLE, executed in S_EXEC and its result is strobed in S_RESP
// a new item is accepted only after the previous one has passed the accept/execute/respond sequence
// and the registered read of the slot ram
// reset (synchronous, active low) clears the slot valid bits and sets the expected number to 1
// results cannot be stalled: o_valid is high for exactly one cycle per item
module in_order_reassembly_buffer_top
    import iorb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_payload_handle,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_handle,
    output logic [31:0] o_out_seq_number,
    output logic        o_next_ready
);

    t_cmd cmd;

    iorb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    iorb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_operation      (i_operation),
        .i_seq_number     (i_seq_number),
        .i_payload_handle (i_payload_handle),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_out_seq_number (o_out_seq_number),
        .o_next_ready     (o_next_ready)
    );

endmodule

### rtl/core/iorb_checker.sv
`timescale 1ns / 1ps
// port-level checker of the reassembly buffer and its bind
module iorb_checker
    import iorb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_handle,
    input logic [31:0] o_out_seq_number
);

    // every accepted transfer is followed by its result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_valid)
        else $error("result strobe missing after transfer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("strobe longer than one cycle or busy stuck");

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe without an item in flight");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DELIVERED |-> o_out_handle == '0 && o_out_seq_number == '0)
        else $error("handle or number nonzero without delivery");

endmodule

bind in_order_reassembly_buffer_top iorb_checker u_iorb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_out_handle     (o_out_handle),
    .o_out_seq_number (o_out_seq_number)
);

### tb/in_order_reassembly_buffer_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the in-order reassembly buffer top level
module in_order_reassembly_buffer_top_tb;
    import iorb_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int MAX_GAP        = 14;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        t_status status;
        t_handle handle;
        t_seq    seq;
        logic    next_ready;
    } t_result_rec;

    // in-order delivery tracker: mirrors the window and holds the awaited results
    class reorder_tracker;
        t_seq        exp_seq;
        logic        slot_valid [WINDOW_DEPTH];
        t_store      slot_handle[WINDOW_DEPTH];
        t_result_rec awaited_q[$];
        int          errors;
        int          n_delivered, n_stored, n_not_ready, n_rejected;

        function new();
            exp_seq = t_seq'(1);
            foreach (slot_valid[i]) begin
                slot_valid[i]  = 1'b0;
                slot_handle[i] = '0;
            end
            errors      = 0;
            n_delivered = 0;
            n_stored    = 0;
            n_not_ready = 0;
            n_rejected  = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function void note_transfer(input logic op, input t_seq seq, input t_handle hdl);
            t_result_rec rec;
            t_seq        seq_dist;
            int unsigned idx;
            rec.status = ST_NOT_READY;
            rec.handle = '0;
            rec.seq    = '0;
            if (t_op'(op) == OP_APPEND) begin
                seq_dist = seq - exp_seq;
                idx      = seq % WINDOW_DEPTH;
                if (seq_dist >= WINDOW_DEPTH || slot_valid[idx]) begin
                    rec.status = ST_REJECTED;
                    n_rejected++;
                end else begin
                    slot_valid[idx]  = 1'b1;
                    slot_handle[idx] = hdl[STORE_W-1:0];
                    rec.status = ST_STORED;
                    n_stored++;
                end
            end else begin
                idx = exp_seq % WINDOW_DEPTH;
                if (slot_valid[idx]) begin
                    rec.handle      = t_handle'(slot_handle[idx]);
                    rec.seq         = exp_seq;
                    slot_valid[idx] = 1'b0;
                    exp_seq         = exp_seq + t_seq'(1);
                    rec.status      = ST_DELIVERED;
                    n_delivered++;
                end else begin
                    n_not_ready++;
                end
            end
            rec.next_ready = slot_valid[exp_seq % WINDOW_DEPTH];
            awaited_q.push_back(rec);
        endfunction

        function void check_result(input logic [1:0] st, input t_handle hdl,
                                   input t_seq seq, input logic nr);
            t_result_rec rec;
            if (awaited_q.size() == 0) begin
                $display("%0t: result with nothing awaited: status %0d handle %h seq %h",
                         $time, st, hdl, seq);
                errors++;
                return;
            end
            rec = awaited_q.pop_front();
            if (st !== rec.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, rec.status, st);
                errors++;
            end
            if (hdl !== rec.handle) begin
                $display("%0t: out_handle mismatch: expected %h actual %h",
                         $time, rec.handle, hdl);
                errors++;
            end
            if (seq !== rec.seq) begin
                $display("%0t: out_seq_number mismatch: expected %h actual %h",
                         $time, rec.seq, seq);
                errors++;
            end
            if (nr !== rec.next_ready) begin
                $display("%0t: next_ready mismatch: expected %b actual %b",
                         $time, rec.next_ready, nr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [31:0] i_seq_number;
    logic [31:0] i_payload_handle;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_out_handle;
    logic [31:0] o_out_seq_number;
    logic        o_next_ready;

    reorder_tracker sb;
    int             idle_cycles;

    in_order_reassembly_buffer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_seq_number     (i_seq_number),
        .i_payload_handle (i_payload_handle),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_out_seq_number (o_out_seq_number),
        .o_next_ready     (o_next_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // sample both sides at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                sb.check_result(o_status, o_out_handle, o_out_seq_number, o_next_ready);
            end
            if (start && !busy) begin
                sb.note_transfer(i_operation, i_seq_number, i_payload_handle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("in_order_reassembly_buffer_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input t_op op, input t_seq seq, input t_handle hdl,
                             input int gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start            = 1'b1;
        i_operation      = op;
        i_seq_number     = seq;
        i_payload_handle = hdl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic append(input t_seq seq, input t_handle hdl);
        send_item(OP_APPEND, seq, hdl, $urandom_range(0, MAX_GAP));
    endtask

    task automatic retrieve();
        send_item(OP_RETRIEVE, t_seq'($urandom), t_handle'($urandom),
                  $urandom_range(0, MAX_GAP));
    endtask

    // hold the sender off until every awaited result has arrived
    task automatic drain();
        start = 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int   r;
        int   gap;
        int   off;
        t_op  op;
        t_seq seq;
        sb               = new();
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_operation      = OP_APPEND;
        i_seq_number     = '0;
        i_payload_handle = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty retrieve, window edges, duplicates, handle extremes
        retrieve();
        append(32'h0000_0000, 32'h0000_0000);
        append(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        append(32'd65, 32'h1234_5678);
        append(32'd64, 32'hFFFF_FFFF);
        append(32'd64, 32'h0000_0001);
        append(32'd2, 32'h0000_0000);
        retrieve();
        append(32'd1, 32'hA5A5_A5A5);
        retrieve();
        retrieve();
        append(32'd1, 32'h0BAD_0BAD);
        append(32'd66, 32'h5555_AAAA);
        append(32'd67, 32'hAAAA_5555);
        append(32'h8000_0000, 32'h5A5A_5A5A);
        append(32'd3, 32'h7FFF_FFFF);
        retrieve();
        retrieve();
        append(32'd4, 32'h8000_0000);
        retrieve();
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r   = $urandom_range(0, 99);
            op  = OP_APPEND;
            seq = t_seq'($urandom);
            if (r < 40) begin
                seq = sb.exp_seq + t_seq'($urandom_range(0, 7));
            end else if (r < 55) begin
                seq = sb.exp_seq + t_seq'($urandom_range(0, WINDOW_DEPTH - 1));
            end else if (r < 85) begin
                op = OP_RETRIEVE;
            end else if (r < 93) begin
                // just below the window, or just inside or just outside its upper end
                off = $urandom_range(0, 6);
                if (off < 2) begin
                    seq = sb.exp_seq - t_seq'(off + 1);
                end else begin
                    seq = sb.exp_seq + t_seq'(WINDOW_DEPTH - 4 + off);
                end
            end
            gap = (i >= 600 && i < 800) ? 0 : $urandom_range(0, MAX_GAP);
            send_item(op, seq, t_handle'($urandom), gap);
            if (i % 250 == 249) begin
                drain();
            end
        end

        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d delivered, %0d stored, %0d not_ready, %0d rejected",
                 sb.n_delivered, sb.n_stored, sb.n_not_ready, sb.n_rejected);
        $display("final expected number %0d, %0d check errors", sb.exp_seq, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("in_order_reassembly_buffer_top regression: pass");
        end else begin
            $display("in_order_reassembly_buffer_top regression: fail");
        end
        $finish;
    end

endmodule
